// ----- src/u8d_pkg.sv -----
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
    localparam logic [20:0] END_CP         = 21'h000000;

    localparam logic [7:0] END_BYTE   = 8'h00;
    localparam logic [7:0] ASCII_MIN  = 8'h01;
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] LEAD2_MIN  = 8'hC0;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF7;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    localparam logic [1:0] NEED_NONE  = 2'd0;
    localparam logic [1:0] NEED_ONE   = 2'd1;
    localparam logic [1:0] NEED_TWO   = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    // One decoded byte's worth of work for the back end: a run of
    // replacements, optionally followed by one final result.
    typedef struct packed {
        logic [1:0]  n_repl;
        logic        has_final;
        logic [20:0] code_point;
        logic        malformed;
        logic        end_of_text;
        logic [2:0]  seq_bytes;
    } t_job;

endpackage

// ----- src/u8d_if.sv -----
// Channel interfaces: raw text bytes in, decoded code points out.
interface u8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic        malformed;
    logic        end_of_text;
    logic [2:0]  seq_bytes;
    logic        last_of_run;

    modport source (output valid, output code_point, output malformed,
                    output end_of_text, output seq_bytes, output last_of_run,
                    input ready);
    modport sink   (input valid, input code_point, input malformed,
                    input end_of_text, input seq_bytes, input last_of_run,
                    output ready);
endinterface

// ----- src/u8d_front.sv -----
// Front end: takes bytes, tracks the held sequence and issues jobs.
module u8d_front import u8d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    output logic       o_ready,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [7:0] r_lead, n_lead;
    logic [1:0] r_needed, n_needed;
    logic [1:0] r_held, n_held;
    logic [5:0] r_pay [2];

    logic       accept;
    logic       is_cont;
    logic       complete;
    logic       do_fresh;
    logic       pay_we;
    logic [5:0] pay;
    t_job       job;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign is_cont  = (i_byte[7:6] == CONT_TAG);
    assign pay      = i_byte[5:0];
    assign complete = ({1'b0, r_held} + 3'd1) >= {1'b0, r_needed};

    always_comb begin
        job      = '0;
        n_lead   = r_lead;
        n_needed = r_needed;
        n_held   = r_held;
        pay_we   = 1'b0;
        do_fresh = 1'b0;

        if (r_needed == NEED_NONE) begin
            do_fresh = 1'b1;
        end else if (is_cont) begin
            if (complete) begin
                job.has_final = 1'b1;
                job.seq_bytes = {1'b0, r_needed} + 3'd1;
                case (r_needed)
                    NEED_ONE:   job.code_point = {10'd0, r_lead[4:0], pay};
                    NEED_TWO:   job.code_point = {5'd0, r_lead[3:0], r_pay[0], pay};
                    NEED_THREE: job.code_point = {r_lead[2:0], r_pay[0], r_pay[1], pay};
                    default:    job.code_point = END_CP;
                endcase
                n_lead   = '0;
                n_needed = NEED_NONE;
                n_held   = '0;
            end else begin
                pay_we = 1'b1;
                n_held = r_held + 2'd1;
            end
        end else begin
            // broken sequence: one replacement for the lead, one per held byte
            job.n_repl = r_held + 2'd1;
            n_lead     = '0;
            n_needed   = NEED_NONE;
            n_held     = '0;
            do_fresh   = 1'b1;
        end

        if (do_fresh) begin
            case (i_byte) inside
                END_BYTE: begin
                    job.has_final   = 1'b1;
                    job.code_point  = END_CP;
                    job.end_of_text = 1'b1;
                    job.seq_bytes   = 3'd0;
                end
                [ASCII_MIN:ASCII_MAX]: begin
                    job.has_final  = 1'b1;
                    job.code_point = {13'd0, i_byte};
                    job.seq_bytes  = 3'd1;
                end
                [LEAD2_MIN:LEAD2_MAX]: begin
                    n_lead = i_byte; n_needed = NEED_ONE; n_held = '0;
                end
                [LEAD3_MIN:LEAD3_MAX]: begin
                    n_lead = i_byte; n_needed = NEED_TWO; n_held = '0;
                end
                [LEAD4_MIN:LEAD4_MAX]: begin
                    n_lead = i_byte; n_needed = NEED_THREE; n_held = '0;
                end
                default: begin
                    // stray continuation or invalid lead
                    job.has_final  = 1'b1;
                    job.code_point = REPLACEMENT_CP;
                    job.malformed  = 1'b1;
                    job.seq_bytes  = 3'd1;
                end
            endcase
        end
    end

    assign o_job  = job;
    assign o_push = accept && (job.has_final || (job.n_repl != 2'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead   <= '0;
            r_needed <= NEED_NONE;
            r_held   <= '0;
        end else if (accept) begin
            r_lead   <= n_lead;
            r_needed <= n_needed;
            r_held   <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && pay_we) begin
            r_pay[r_held[0]] <= pay;
        end
    end

endmodule

// ----- src/u8d_queue.sv -----
// Short job queue between front and back ends.
module u8d_queue import u8d_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + PW'(1);
            if (do_pop)  r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + PW'(1);
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/u8d_back.sv -----
// Back end: expands each job into results and holds the output register.
module u8d_back import u8d_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_job_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [20:0] o_code_point,
    output logic        o_malformed,
    output logic        o_end_of_text,
    output logic [2:0]  o_seq_bytes,
    output logic        o_last_of_run
);

    logic        r_valid;
    logic [1:0]  r_idx;
    logic [20:0] r_cp;
    logic        r_bad, r_eot, r_last;
    logic [2:0]  r_seq;

    logic        load;
    logic        is_repl;
    logic        is_last;
    logic [2:0]  total;

    assign load    = i_job_valid && (!r_valid || i_ready);
    assign total   = {1'b0, i_job.n_repl} + {2'b00, i_job.has_final};
    assign is_repl = (r_idx < i_job.n_repl);
    assign is_last = ({1'b0, r_idx} == (total - 3'd1));
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_last <= is_last;
            if (is_repl) begin
                r_cp  <= REPLACEMENT_CP;
                r_bad <= 1'b1;
                r_eot <= 1'b0;
                r_seq <= 3'd1;
            end else begin
                r_cp  <= i_job.code_point;
                r_bad <= i_job.malformed;
                r_eot <= i_job.end_of_text;
                r_seq <= i_job.seq_bytes;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_code_point  = r_cp;
    assign o_malformed   = r_bad;
    assign o_end_of_text = r_eot;
    assign o_seq_bytes   = r_seq;
    assign o_last_of_run = r_last;

endmodule

// ----- src/utf8_stream_decoder.sv -----
// Top level of the streaming UTF-8 decoder.
//
// Takes one text byte per transfer and returns decoded code points. A well
// formed stream runs at one byte per clock while the receiver is ready:
// ASCII bytes and completed sequences each give one result; leads and
// inner continuations give none. A byte with k results (a broken sequence
// gives up to four) holds the back end until all are out, one per cycle
// while the receiver is ready; the job queue of QUEUE_DEPTH entries lets
// the front take bytes until it fills. Results pass through the job queue
// and the output register. Malformed input is replaced by 0xFFFD; a zero
// byte flushes any held sequence and then gives an end marker, after which
// decoding continues. No overlong or surrogate checks are made.
module utf8_stream_decoder import u8d_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    u8d_byte_if.sink i_byte,
    u8d_cp_if.source o_cp
);

    // front to queue
    logic q_full, q_push;
    t_job job_in;

    // queue to back
    logic q_valid, q_pop;
    t_job job_out;

    u8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .i_byte  (i_byte.in_byte),
        .o_ready (i_byte.ready),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (job_in)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (job_out)
    );

    // back end: one result per cycle, while the receiver is ready, into the output register
    u8d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (job_out),
        .o_pop         (q_pop),
        .o_valid       (o_cp.valid),
        .i_ready       (o_cp.ready),
        .o_code_point  (o_cp.code_point),
        .o_malformed   (o_cp.malformed),
        .o_end_of_text (o_cp.end_of_text),
        .o_seq_bytes   (o_cp.seq_bytes),
        .o_last_of_run (o_cp.last_of_run)
    );

endmodule

// ----- sim/utf8_stream_decoder_test.sv -----
// Self-checking testbench for the UTF-8 stream decoder: directed and random text.
module utf8_stream_decoder_test import u8d_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // One decoded result as seen on the output channel.
    typedef struct packed {
        logic [20:0] code_point;
        logic        malformed;
        logic        end_of_text;
        logic [2:0]  seq_bytes;
        logic        last_of_run;
    } t_cp_result;

    // Decoder state mirror plus the queue of code points still owed by the block.
    class cp_scoreboard;
        t_cp_result  owed_q[$];
        t_cp_result  run_q[$];      // results caused by the byte being noted
        logic [7:0]  lead_byte;
        logic [5:0]  cont_bits[2];
        logic [1:0]  conts_needed;
        logic [1:0]  conts_held;
        int          errors;
        int          bytes_seen;
        int          results_seen;
        int          repl_seen;
        int          eot_seen;

        function new();
            lead_byte    = 8'h00;
            cont_bits[0] = 6'h00;
            cont_bits[1] = 6'h00;
            conts_needed = NEED_NONE;
            conts_held   = 2'd0;
            errors       = 0;
            bytes_seen   = 0;
            results_seen = 0;
            repl_seen    = 0;
            eot_seen     = 0;
        endfunction

        function void add_result(logic [20:0] cp, logic bad, logic eot, logic [2:0] seq);
            t_cp_result r;
            r.code_point  = cp;
            r.malformed   = bad;
            r.end_of_text = eot;
            r.seq_bytes   = seq;
            r.last_of_run = 1'b0;
            run_q.push_back(r);
        endfunction

        function void drop_hold();
            lead_byte    = 8'h00;
            conts_needed = NEED_NONE;
            conts_held   = 2'd0;
        endfunction

        // Byte arriving with nothing held.
        function void take_fresh(logic [7:0] b);
            if (b == END_BYTE) begin
                add_result(END_CP, 1'b0, 1'b1, 3'd0);
            end else if (b <= ASCII_MAX) begin
                add_result({13'd0, b}, 1'b0, 1'b0, 3'd1);
            end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
                lead_byte = b; conts_needed = NEED_ONE; conts_held = 2'd0;
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
                lead_byte = b; conts_needed = NEED_TWO; conts_held = 2'd0;
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
                lead_byte = b; conts_needed = NEED_THREE; conts_held = 2'd0;
            end else begin
                // stray continuation or F8..FF
                add_result(REPLACEMENT_CP, 1'b1, 1'b0, 3'd1);
            end
        endfunction

        // Accepted input transfer: work out every result it owes.
        function void note_byte(logic [7:0] b);
            logic [20:0] cp;
            bytes_seen++;
            run_q.delete();
            if (conts_needed == NEED_NONE) begin
                take_fresh(b);
            end else if (b[7:6] == CONT_TAG) begin
                if (int'(conts_held) + 1 >= int'(conts_needed)) begin
                    case (conts_needed)
                        NEED_ONE:   cp = {10'd0, lead_byte[4:0], b[5:0]};
                        NEED_TWO:   cp = {5'd0, lead_byte[3:0], cont_bits[0], b[5:0]};
                        default:    cp = {lead_byte[2:0], cont_bits[0], cont_bits[1],
                                          b[5:0]};
                    endcase
                    add_result(cp, 1'b0, 1'b0, {1'b0, conts_needed} + 3'd1);
                    drop_hold();
                end else begin
                    cont_bits[conts_held[0]] = b[5:0];
                    conts_held = conts_held + 2'd1;
                end
            end else begin
                // broken sequence: one replacement for the lead, one per held continuation
                add_result(REPLACEMENT_CP, 1'b1, 1'b0, 3'd1);
                for (int k = 0; k < int'(conts_held); k++)
                    add_result(REPLACEMENT_CP, 1'b1, 1'b0, 3'd1);
                drop_hold();
                take_fresh(b);
            end
            if (run_q.size() > 0)
                run_q[run_q.size() - 1].last_of_run = 1'b1;
            foreach (run_q[i])
                owed_q.push_back(run_q[i]);
        endfunction

        function void check_result(t_cp_result got);
            t_cp_result want;
            results_seen++;
            if (got.malformed === 1'b1) repl_seen++;
            if (got.end_of_text === 1'b1) eot_seen++;
            if (owed_q.size() == 0) begin
                $error("result with nothing owed: code_point %h", got.code_point);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (got.code_point !== want.code_point) begin
                $error("code_point: expected %h, got %h", want.code_point, got.code_point);
                errors++;
            end
            if (got.malformed !== want.malformed) begin
                $error("malformed: expected %b, got %b", want.malformed, got.malformed);
                errors++;
            end
            if (got.end_of_text !== want.end_of_text) begin
                $error("end_of_text: expected %b, got %b", want.end_of_text,
                       got.end_of_text);
                errors++;
            end
            if (got.seq_bytes !== want.seq_bytes) begin
                $error("seq_bytes: expected %0d, got %0d", want.seq_bytes, got.seq_bytes);
                errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %b, got %b", want.last_of_run,
                       got.last_of_run);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   gaps_on;      // cleared for a stretch of back-to-back traffic

    u8d_byte_if byte_ch ();
    u8d_cp_if   cp_ch ();

    utf8_stream_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch.sink),
        .o_cp    (cp_ch.source)
    );

    cp_scoreboard sb = new();

    // Directed text: end marker with nothing held, ASCII extremes, every
    // sequence length, the largest code point, stray continuation, invalid
    // lead, broken sequences with zero, one and two held continuations
    // (the last giving four results), and a zero byte that flushes a lead.
    logic [7:0] directed_text[$] = '{
        8'h00, 8'h01, 8'h7F,
        8'hC3, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'h80, 8'hFF,
        8'hC0, 8'h41,
        8'hE0, 8'h80, 8'h41,
        8'hF0, 8'h80, 8'h80, 8'hF8,
        8'hE1, 8'h00
    };
    logic [7:0] random_text[$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Receiver: drops ready about one cycle in ten unless gaps are off.
    always @(posedge i_clk)
        cp_ch.ready <= (!gaps_on || $urandom_range(0, 99) >= 10);

    // Sample at the falling edge, where everything driven at the rising edge
    // has settled; a transfer seen here completes at the next rising edge.
    always @(negedge i_clk) begin
        t_cp_result got;
        if (i_rst_n) begin
            if (byte_ch.valid && byte_ch.ready)
                sb.note_byte(byte_ch.in_byte);
            if (cp_ch.valid && cp_ch.ready) begin
                got.code_point  = cp_ch.code_point;
                got.malformed   = cp_ch.malformed;
                got.end_of_text = cp_ch.end_of_text;
                got.seq_bytes   = cp_ch.seq_bytes;
                got.last_of_run = cp_ch.last_of_run;
                sb.check_result(got);
            end
        end
    end

    // Offer one byte and hold it until the transfer; called at a rising edge.
    task automatic send_text_byte(input logic [7:0] b);
        logic took;
        if (gaps_on && $urandom_range(0, 99) < 10) begin
            byte_ch.valid   <= 1'b0;
            byte_ch.in_byte <= 8'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do begin
            @(negedge i_clk);
            took = byte_ch.valid && byte_ch.ready;
            @(posedge i_clk);
        end while (!took);
    endtask

    // Random text: mostly well-formed characters with random payload, plus
    // truncated sequences, raw noise and the odd end of text.
    function automatic void build_random_text(int count);
        int         pick;
        int         len;
        int         conts;
        logic [7:0] b;
        while (random_text.size() < count) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            if (pick < 65) begin
                case (len)
                    1:       random_text.push_back(8'($urandom_range(1, 127)));
                    2:       random_text.push_back({3'b110, 5'($urandom)});
                    3:       random_text.push_back({4'b1110, 4'($urandom)});
                    default: random_text.push_back({5'b11110, 3'($urandom)});
                endcase
                for (int k = 1; k < len; k++)
                    random_text.push_back({CONT_TAG, 6'($urandom)});
            end else if (pick < 85) begin
                // lead cut short by a byte that is not a continuation
                len   = $urandom_range(2, 4);
                conts = $urandom_range(0, len - 2);
                case (len)
                    2:       random_text.push_back({3'b110, 5'($urandom)});
                    3:       random_text.push_back({4'b1110, 4'($urandom)});
                    default: random_text.push_back({5'b11110, 3'($urandom)});
                endcase
                for (int k = 0; k < conts; k++)
                    random_text.push_back({CONT_TAG, 6'($urandom)});
                do b = 8'($urandom); while (b[7:6] == CONT_TAG);
                random_text.push_back(b);
            end else if (pick < 95) begin
                random_text.push_back(8'($urandom));
            end else begin
                random_text.push_back(END_BYTE);
            end
        end
    endfunction

    initial begin
        i_rst_n         <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.in_byte <= 8'h00;
        gaps_on         = 1'b1;
        build_random_text(205);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_text[i])
            send_text_byte(directed_text[i]);

        // middle of the random text runs with no idling on either side
        foreach (random_text[i]) begin
            gaps_on = !(i >= 80 && i < 140);
            send_text_byte(random_text[i]);
        end
        gaps_on = 1'b1;
        byte_ch.valid <= 1'b0;

        while (sb.owed_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Decoded %0d text bytes into %0d results, %0d of them replacements",
                 sb.bytes_seen, sb.results_seen, sb.repl_seen);
        $display("and %0d end markers; %0d mismatches.", sb.eot_seen, sb.errors);
        if (sb.errors == 0 && sb.owed_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #300us;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
src/u8d_pkg.sv
src/u8d_if.sv
src/u8d_front.sv
src/u8d_queue.sv
src/u8d_back.sv
src/utf8_stream_decoder.sv
sim/utf8_stream_decoder_test.sv
